[rtl/ntc_thermistor_temperature_macros.svh]
// assertion macros shared by the thermistor temperature block
`ifndef NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ntc_pkg.sv]
// types, constants and table function for the thermistor temperature block
package ntc_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int LN_TABLE_BITS_DEF = 8;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BETA          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_CENTI_K   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd5;

	// result fields
	localparam int TEMP_W  = 11;
	localparam int FAULT_W = 2;

	// datapath widths
	localparam int LOG_W     = 20;
	localparam int TAB_W     = 17;
	localparam int LOGV_W    = 22;
	localparam int D_W       = 24;
	localparam int LN_W      = 25;
	localparam int DQ_W      = 42;
	localparam int DIV_NUM_W = 55;
	localparam int DIV_DEN_W = 42;

	// arithmetic constants
	localparam logic [31:0] LN2_Q32      = 32'd2977044472;
	localparam logic [6:0]  HUNDRED      = 7'd100;
	localparam logic [22:0] NUM_SCALE    = 23'd6553600;
	localparam logic [16:0] ZERO_C_CENTI = 17'd27315;
	localparam logic [17:0] SAT_CENTI    = 18'd129715;
	localparam logic [17:0] RECIP_100    = 18'd167773;
	localparam int          RECIP_SHIFT  = 24;
	localparam logic signed [TEMP_W-1:0] T_MAX = 11'sd1023;
	localparam logic signed [TEMP_W-1:0] T_MIN = -11'sd273;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE,
		FAULT_ZERO,
		FAULT_HIGH
	} fault_t;

	typedef enum logic [2:0] {
		RES_FAULT_ZERO,
		RES_FAULT_HIGH,
		RES_HOT,
		RES_COLD,
		RES_CALC
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_CHECK,
		ST_LOAD,
		ST_NORM,
		ST_TAB,
		ST_MUL,
		ST_ACC,
		ST_LN,
		ST_PROD,
		ST_DEN,
		ST_DQ,
		ST_TDIV,
		ST_SCALE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       in_ready;
		logic       acc;
		logic       avg_start;
		logic       avg_latch;
		logic       d_clear;
		logic       log_load;
		logic [1:0] log_op;
		logic       norm_shift;
		logic       tab_read;
		logic       log_mul;
		logic       log_acc;
		logic       ln_mul;
		logic       prod_mul;
		logic       den_form;
		logic       tdiv_start;
		logic       tck_latch;
		logic       scale;
		logic       out_load;
		res_sel_t   res_sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic div_done;
		logic avg_zero;
		logic avg_high;
		logic bal_zero;
		logic nom_zero;
		logic norm_done;
		logic dq_pos;
		logic out_free;
	} st_t;

	// log2(1 + i/2^lnb) in unsigned Q1.16 by repeated truncating squaring
	function automatic logic [TAB_W-1:0] log2_entry(int i, int lnb);
		longint unsigned m;
		logic [15:0] r;
		r = '0;
		m = (64'd1 << 30) + (longint'(i) << (30 - lnb));
		if (i == (1 << lnb)) begin
			return 17'h10000;
		end
		for (int b = 15; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r[b] = 1'b1;
			end
		end
		return {1'b0, r};
	endfunction

endpackage

[rtl/ntc_div.sv]
// restoring divider, one quotient bit per cycle
`include "ntc_thermistor_temperature_macros.svh"
module ntc_div #(
	parameter int NUM_W = 55,
	parameter int DEN_W = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             q_bit;
	logic [DEN_W:0]   rem_sub;
	logic             busy;

	assign busy    = (cnt_q != '0);
	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// shift, compare and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			quo_q <= {quo_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`NTC_ASSERT_IMP(a_no_restart, start, !busy, "divider started while busy")
endmodule

[rtl/ntc_dp.sv]
// datapath: config registers, accumulator, log2 unit, Beta equation, result register
`include "ntc_thermistor_temperature_macros.svh"
module ntc_dp #(
	parameter int SAMPLE_BITS   = ntc_pkg::SAMPLE_BITS_DEF,
	parameter int LN_TABLE_BITS = ntc_pkg::LN_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ntc_pkg::cmd_t                       cmd,
	output ntc_pkg::st_t                        st,
	input  logic [SAMPLE_BITS-1:0]              adc_sample,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [ntc_pkg::TEMP_W-1:0]   temperature_c,
	output logic [ntc_pkg::FAULT_W-1:0]         fault_code,
	input  logic                                cfg_write,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ntc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ntc_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + 8;
	localparam int ENT    = (1 << LN_TABLE_BITS) + 1;
	localparam int TIDX_W = LN_TABLE_BITS + 1;
	localparam int FB     = 31 - LN_TABLE_BITS;
	localparam int PAD    = 32 - LOG_W;
	localparam int K_W    = $clog2(LOG_W);
	localparam int PROD_W = TAB_W + FB;

	// configuration registers
	logic [7:0]  cnt_cfg_q;
	logic [19:0] bal_q;
	logic [19:0] nom_q;
	logic [15:0] beta_q;
	logic [15:0] t0_q;
	logic [11:0] fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= 8'd1;
			bal_q     <= 20'd100000;
			nom_q     <= 20'd100000;
			beta_q    <= 16'd3950;
			t0_q      <= 16'd29815;
			fs_q      <= 12'd4095;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SAMPLE_COUNT: cnt_cfg_q <= cfg_data[7:0];
				REG_BALANCE:      bal_q     <= cfg_data[19:0];
				REG_NOMINAL:      nom_q     <= cfg_data[19:0];
				REG_BETA:         beta_q    <= cfg_data[15:0];
				REG_REF_CENTI_K:  t0_q      <= cfg_data[15:0];
				REG_FULL_SCALE:   fs_q      <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// sample accumulator
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       taken_q;
	logic [SUM_W-1:0] sum_next;
	logic [8:0]       n_next;
	logic [8:0]       limit;

	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign n_next   = {1'b0, taken_q} + 9'd1;
	assign limit    = {(cnt_cfg_q == 8'd0), cnt_cfg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.avg_start) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.acc) begin
			sum_q   <= sum_next;
			taken_q <= n_next[7:0];
		end
	end

	// shared divider: average, then temperature
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [DIV_NUM_W-1:0] num_q;
	logic signed [DQ_W-1:0] dq_q;

	assign div_start = cmd.avg_start || cmd.tdiv_start;
	assign div_num   = cmd.avg_start ? DIV_NUM_W'(sum_next) : num_q;
	assign div_den   = cmd.avg_start ? DIV_DEN_W'(n_next) : DIV_DEN_W'(dq_q);

	ntc_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// average
	logic [SAMPLE_BITS-1:0] avg_q;

	always_ff @(posedge clk) begin
		if (cmd.avg_latch) begin
			avg_q <= div_quo[SAMPLE_BITS-1:0];
		end
	end

	// log2 operand select
	logic [LOG_W-1:0] fs_ext;
	logic [LOG_W-1:0] avg_ext;
	logic [LOG_W-1:0] log_opnd;

	assign fs_ext  = LOG_W'(fs_q);
	assign avg_ext = LOG_W'(avg_q);

	always_comb begin
		case (cmd.log_op)
			2'd0:    log_opnd = bal_q;
			2'd1:    log_opnd = fs_ext - avg_ext;
			2'd2:    log_opnd = avg_ext;
			2'd3:    log_opnd = nom_q;
			default: log_opnd = bal_q;
		endcase
	end

	// normalizer, one bit per cycle
	logic [LOG_W-1:0] norm_q;
	logic [K_W-1:0]   k_q;

	always_ff @(posedge clk) begin
		if (cmd.log_load) begin
			norm_q <= log_opnd;
			k_q    <= K_W'(LOG_W - 1);
		end else if (cmd.norm_shift) begin
			norm_q <= {norm_q[LOG_W-2:0], 1'b0};
			k_q    <= k_q - K_W'(1);
		end
	end

	// mantissa table, two registered reads
	logic [TAB_W-1:0]         tab [ENT];
	logic [LN_TABLE_BITS-1:0] idx;
	logic [TIDX_W-1:0]        idx_lo;
	logic [TIDX_W-1:0]        idx_hi;
	logic [FB-1:0]            rem;
	logic [TAB_W-1:0]         lo_q;
	logic [TAB_W-1:0]         hi_q;
	logic [TAB_W-1:0]         tab_diff;
	logic [PROD_W-1:0]        prod_q;
	logic [LOGV_W-1:0]        logv;
	logic signed [D_W-1:0]    d_q;

	for (genvar g = 0; g < ENT; g++) begin : g_tab
		assign tab[g] = log2_entry(g, LN_TABLE_BITS);
	end

	assign idx      = norm_q[LOG_W-2 -: LN_TABLE_BITS];
	assign idx_lo   = {1'b0, idx};
	assign idx_hi   = idx_lo + TIDX_W'(1);
	assign rem      = {norm_q[LOG_W-2-LN_TABLE_BITS:0], {PAD{1'b0}}};
	assign tab_diff = (hi_q > lo_q) ? (hi_q - lo_q) : '0;
	assign logv     = LOGV_W'({k_q, 16'b0}) + LOGV_W'(lo_q)
	                  + LOGV_W'(prod_q[PROD_W-1:FB]);

	always_ff @(posedge clk) begin
		if (cmd.tab_read) begin
			lo_q <= tab[idx_lo];
			hi_q <= tab[idx_hi];
		end
		if (cmd.log_mul) begin
			prod_q <= tab_diff * rem;
		end
	end

	// signed sum of the four logs
	always_ff @(posedge clk) begin
		if (cmd.d_clear) begin
			d_q <= '0;
		end else if (cmd.log_acc) begin
			if (cmd.log_op[1]) begin
				d_q <= d_q - $signed(D_W'(logv));
			end else begin
				d_q <= d_q + $signed(D_W'(logv));
			end
		end
	end

	// natural log, products, denominator and numerator
	logic [D_W-1:0]          mag;
	logic [D_W+31:0]         ln_prod;
	logic signed [LN_W-1:0]  ln_q;
	logic signed [16:0]      t0_s;
	logic [31:0]             bt_q;
	logic [22:0]             b100_q;
	logic signed [DQ_W-1:0]  tln_q;

	assign mag     = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
	assign ln_prod = mag * LN2_Q32;
	assign t0_s    = {1'b0, t0_q};

	always_ff @(posedge clk) begin
		if (cmd.ln_mul) begin
			if (d_q[D_W-1]) begin
				ln_q <= -$signed(LN_W'(ln_prod[D_W+31:32]));
			end else begin
				ln_q <= $signed(LN_W'(ln_prod[D_W+31:32]));
			end
		end
		if (cmd.prod_mul) begin
			bt_q   <= beta_q * t0_q;
			b100_q <= beta_q * HUNDRED;
			tln_q  <= t0_s * ln_q;
		end
		if (cmd.den_form) begin
			dq_q  <= $signed({3'b0, b100_q, 16'b0}) + tln_q;
			num_q <= bt_q * NUM_SCALE;
		end
	end

	// centikelvin to degrees celsius
	logic [DIV_NUM_W-1:0]  tck_q;
	logic                  tck_ge;
	logic [16:0]           cc_mag;
	logic [34:0]           mq_q;
	logic                  sat_q;
	logic                  neg_q;
	logic [TEMP_W-1:0]     deg;
	logic signed [TEMP_W-1:0] temp_calc;

	assign tck_ge = (tck_q >= DIV_NUM_W'(ZERO_C_CENTI));
	assign cc_mag = tck_ge ? (tck_q[16:0] - ZERO_C_CENTI) : (ZERO_C_CENTI - tck_q[16:0]);
	assign deg    = mq_q[RECIP_SHIFT +: TEMP_W];

	always_ff @(posedge clk) begin
		if (cmd.tck_latch) begin
			tck_q <= div_quo;
		end
		if (cmd.scale) begin
			sat_q <= (tck_q >= DIV_NUM_W'(SAT_CENTI));
			neg_q <= !tck_ge;
			mq_q  <= cc_mag * RECIP_100;
		end
	end

	always_comb begin
		if (sat_q) begin
			temp_calc = T_MAX;
		end else if (neg_q) begin
			temp_calc = -$signed(deg);
		end else begin
			temp_calc = $signed(deg);
		end
	end

	// result register
	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	fault_t                   fault_q;
	logic signed [TEMP_W-1:0] temp_d;
	fault_t                   fault_d;
	logic                     out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.res_sel)
			RES_FAULT_ZERO: begin
				temp_d  = '0;
				fault_d = FAULT_ZERO;
			end
			RES_FAULT_HIGH: begin
				temp_d  = '0;
				fault_d = FAULT_HIGH;
			end
			RES_HOT: begin
				temp_d  = T_MAX;
				fault_d = FAULT_NONE;
			end
			RES_COLD: begin
				temp_d  = T_MIN;
				fault_d = FAULT_NONE;
			end
			default: begin
				temp_d  = temp_calc;
				fault_d = FAULT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			temp_q  <= temp_d;
			fault_q <= fault_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign temperature_c = temp_q;
	assign fault_code    = fault_q;

	// status to the controller
	assign st.last      = (n_next >= limit);
	assign st.div_done  = div_done;
	assign st.avg_zero  = (avg_q == '0);
	assign st.avg_high  = (avg_ext >= fs_ext);
	assign st.bal_zero  = (bal_q == '0);
	assign st.nom_zero  = (nom_q == '0);
	assign st.norm_done = norm_q[LOG_W-1];
	assign st.dq_pos    = !dq_q[DQ_W-1] && (dq_q != '0);
	assign st.out_free  = out_free;

	`NTC_ASSERT_IMP(a_no_overwrite, cmd.out_load, out_free, "result overwritten before taken")
	`NTC_ASSERT_IMP(a_fault_zero_temp, out_valid_q && (fault_q != FAULT_NONE), temp_q == '0, "fault result with nonzero temperature")
	`NTC_ASSERT_NXT(a_group_restart, cmd.avg_start, (sum_q == '0) && (taken_q == '0), "accumulator not cleared after group")
endmodule

[rtl/ntc_ctrl.sv]
// controller: sequences averaging, the four log2 passes and the Beta equation
`include "ntc_thermistor_temperature_macros.svh"
module ntc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  ntc_pkg::st_t  st,
	output ntc_pkg::cmd_t cmd
);
	import ntc_pkg::*;

	state_t   state_q, state_d;
	logic [1:0] op_q, op_d;
	res_sel_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= 2'd0;
			res_q   <= RES_CALC;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			res_q   <= res_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		res_d   = res_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && st.last) state_d = ST_AVG;
			end
			ST_AVG: begin
				if (st.div_done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.avg_zero) begin
					res_d   = RES_FAULT_ZERO;
					state_d = ST_OUT;
				end else if (st.avg_high) begin
					res_d   = RES_FAULT_HIGH;
					state_d = ST_OUT;
				end else if (st.bal_zero) begin
					res_d   = RES_HOT;
					state_d = ST_OUT;
				end else if (st.nom_zero) begin
					res_d   = RES_COLD;
					state_d = ST_OUT;
				end else begin
					op_d    = 2'd0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_NORM;
			ST_NORM: begin
				if (st.norm_done) state_d = ST_TAB;
			end
			ST_TAB: state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (op_q == 2'd3) begin
					state_d = ST_LN;
				end else begin
					op_d    = op_q + 2'd1;
					state_d = ST_LOAD;
				end
			end
			ST_LN:   state_d = ST_PROD;
			ST_PROD: state_d = ST_DEN;
			ST_DEN:  state_d = ST_DQ;
			ST_DQ: begin
				if (st.dq_pos) begin
					state_d = ST_TDIV;
				end else begin
					res_d   = RES_HOT;
					state_d = ST_OUT;
				end
			end
			ST_TDIV: begin
				if (st.div_done) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				res_d   = RES_CALC;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.log_op  = op_q;
		cmd.res_sel = res_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready  = 1'b1;
				cmd.acc       = in_valid && !st.last;
				cmd.avg_start = in_valid && st.last;
			end
			ST_AVG:   cmd.avg_latch  = st.div_done;
			ST_CHECK: cmd.d_clear    = 1'b1;
			ST_LOAD:  cmd.log_load   = 1'b1;
			ST_NORM:  cmd.norm_shift = !st.norm_done;
			ST_TAB:   cmd.tab_read   = 1'b1;
			ST_MUL:   cmd.log_mul    = 1'b1;
			ST_ACC:   cmd.log_acc    = 1'b1;
			ST_LN:    cmd.ln_mul     = 1'b1;
			ST_PROD:  cmd.prod_mul   = 1'b1;
			ST_DEN:   cmd.den_form   = 1'b1;
			ST_DQ:    cmd.tdiv_start = st.dq_pos;
			ST_TDIV:  cmd.tck_latch  = st.div_done;
			ST_SCALE: cmd.scale      = 1'b1;
			ST_OUT:   cmd.out_load   = st.out_free;
			default: ;
		endcase
	end

	`NTC_ASSERT_IMP(a_done_expected, st.div_done, state_q == ST_AVG || state_q == ST_TDIV, "divider finished outside a wait state")
endmodule

[rtl/ntc_thermistor_temperature.sv]
// top level of the NTC thermistor temperature block
// Sums groups of ADC samples and turns each group average into degrees Celsius
// through the Beta equation in Q16.16. A sample that does not close a group is
// accumulated in the idle state and samples may follow back to back. The
// sample that closes a group occupies the block through the shared 55-step
// restoring divider, used once for the average and once for the temperature,
// and four passes of the log2 unit, whose normalizer shifts one bit per
// cycle; each pass loads its operand, normalizes it, reads the table,
// interpolates and accumulates. A fault or a zero resistor setting skips the
// math. Input is held off during that time, and longer while a previous
// result still waits in the output register; a waiting result does not block
// the samples of the next group until that group closes.
module ntc_thermistor_temperature #(
	parameter int SAMPLE_BITS   = ntc_pkg::SAMPLE_BITS_DEF,
	parameter int LN_TABLE_BITS = ntc_pkg::LN_TABLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SAMPLE_BITS-1:0]             adc_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_c,
	output logic [ntc_pkg::FAULT_W-1:0]        fault_code,
	input  logic                               cfg_write,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ntc_pkg::*;

	cmd_t cmd;
	st_t  st;

	// sequencer
	ntc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd)
	);

	// arithmetic and storage
	ntc_dp #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.LN_TABLE_BITS (LN_TABLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.adc_sample    (adc_sample),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.temperature_c (temperature_c),
		.fault_code    (fault_code),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	assign in_ready = cmd.in_ready;
endmodule
